// ----- src/mbda_pkg.sv -----
// ----------------------------------------------------------------------------
// mbda_pkg
// Shared constants and types for the multi-button debounce and activity block.
// ----------------------------------------------------------------------------
package mbda_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int HIST_W      = 8;
    localparam int FIELD_W     = 3;
    localparam int THR_W       = 4;
    localparam int SLEEP_W     = 8;
    localparam int INST_W      = 3;
    localparam int TIME_W      = 32;

    localparam int CNT_W = $clog2(HIST_W + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam int TIMEOUT_UNIT_MS = 5 * 1000;
    localparam int TO_W = $clog2(((1 << SLEEP_W) - 1) * TIMEOUT_UNIT_MS + 1);

    localparam int WAKE_HISTORY = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLER_INSTALLED = 2'd3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic fired;
        logic held;
        logic recent;
    } lane_res_t;

    typedef struct packed {
        logic               active;
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] fired;
    } result_t;

endpackage

// ----- src/mbda_lane.sv -----
// ----------------------------------------------------------------------------
// mbda_lane
// Debounce lane for one button: history, held/done flags and press time.
// ----------------------------------------------------------------------------
module mbda_lane import mbda_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              wake,
    input  logic              pressed,
    input  logic              ok,
    input  logic              installed,
    input  logic [THR_W-1:0]  press_thr,
    input  logic [THR_W-1:0]  release_thr,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TO_W-1:0]   timeout,
    output lane_res_t         res
);

    function automatic logic [CMP_W-1:0] popcount(input logic [HIST_W-1:0] v);
        logic [CMP_W-1:0] n;
        n = '0;
        for (int k = 0; k < HIST_W; k++) begin
            n = n + CMP_W'(v[k]);
        end
        return n;
    endfunction

    logic [HIST_W-1:0] history_reg, history_next;
    logic              held_reg, held_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;

    logic [HIST_W-1:0] shifted;
    logic [CMP_W-1:0]  cnt;
    logic              press_ok;
    logic              release_ok;
    logic [TIME_W-1:0] diff;
    logic              in_window;
    logic              stamp;
    logic              fire;

    assign shifted    = {history_reg[HIST_W-2:0], pressed};
    assign cnt        = popcount(shifted);
    assign press_ok   = pressed && (cnt >= CMP_W'(press_thr));
    assign release_ok = !pressed && (cnt <= CMP_W'(release_thr));
    // wrapping age of the stored press, checked in parallel with the update
    assign diff       = now_ms - press_time_reg;
    assign in_window  = diff < TIME_W'(timeout);

    always_comb begin
        history_next = history_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        stamp        = 1'b0;
        fire         = 1'b0;
        if (wake) begin
            history_next = HIST_W'(WAKE_HISTORY);
            held_next    = 1'b1;
            done_next    = 1'b1;
            stamp        = 1'b1;
        end else begin
            history_next = shifted;
            if (press_ok) begin
                if (!held_reg) begin
                    stamp     = 1'b1;
                    held_next = 1'b1;
                end
                if (!done_reg && installed && ok) begin
                    done_next = 1'b1;
                    fire      = 1'b1;
                end
            end else if (release_ok) begin
                held_next = 1'b0;
                done_next = 1'b0;
            end
        end
        press_time_next = stamp ? now_ms : press_time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg    <= '0;
            held_reg       <= 1'b0;
            done_reg       <= 1'b0;
            press_time_reg <= '0;
        end else if (step_en) begin
            history_reg    <= history_next;
            held_reg       <= held_next;
            done_reg       <= done_next;
            press_time_reg <= press_time_next;
        end
    end

    // a fresh stamp has age zero
    assign res.fired  = fire;
    assign res.held   = held_next;
    assign res.recent = stamp || in_window;

endmodule

// ----- src/mbda_merge.sv -----
// ----------------------------------------------------------------------------
// mbda_merge
// Combines lane results into one item and buffers it in an output/skid pair.
// ----------------------------------------------------------------------------
module mbda_merge import mbda_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lane_res_t lanes [NUM_BUTTONS],
    input  logic      timeout_zero,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_data
);

    result_t merged;
    logic    any_recent;
    logic    accept;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    always_comb begin
        merged     = '0;
        any_recent = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            any_recent = any_recent | lanes[i].recent;
            if (i < FIELD_W) begin
                merged.fired[i] = lanes[i].fired;
                merged.held[i]  = lanes[i].held;
            end
        end
        merged.active = timeout_zero | any_recent;
    end

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_data_next  = merged;
            end
        end else if (accept) begin
            // output stalled, park the item in the skid stage
            skid_valid_next = 1'b1;
            skid_data_next  = merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/multi_button_debounce_activity.sv -----
// ----------------------------------------------------------------------------
// multi_button_debounce_activity
// Per-button shift-register debouncer with press handlers and activity flag.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | content
//  --------+-----+--------------------------------+------------------------------
//  input   | in  | s_tvalid s_tready s_tdata s_tuser | tick or wake, levels, ok, time
//  result  | out | m_tvalid m_tready m_tdata      | fired, held, active
//  config  | in  | cfg_we cfg_index cfg_wdata     | four registers, write only
//
//  one item per cycle while s_tready is high; results are registered
//  all buttons update in parallel lanes in the accept cycle, the merge
//  stage registers the combined result
//  an output register plus one skid entry lets an item be taken while a
//  result waits; s_tready drops only when both are full
//  reset is synchronous and clears lane state, timeout, handler and valid registers
// ----------------------------------------------------------------------------
module multi_button_debounce_activity import mbda_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key_levels[2:0], handler_ok[5:3], now_ms[37:6], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // fired[2:0], held[5:3], active[6], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [TO_W-1:0]   timeout_reg, timeout_next;
    logic [THR_W-1:0]  press_thr_reg, press_thr_next;
    logic [THR_W-1:0]  release_thr_reg, release_thr_next;
    logic [INST_W-1:0] installed_reg, installed_next;

    logic [FIELD_W-1:0] key_levels;
    logic [FIELD_W-1:0] handler_ok;
    logic [TIME_W-1:0]  now_ms;
    logic               step_en;
    lane_res_t          lane_res [NUM_BUTTONS];
    result_t            out_data;

    assign key_levels = s_tdata[FIELD_W-1:0];
    assign handler_ok = s_tdata[2*FIELD_W-1:FIELD_W];
    assign now_ms     = s_tdata[2*FIELD_W+TIME_W-1:2*FIELD_W];
    assign step_en    = s_tvalid && s_tready;

    always_comb begin
        timeout_next     = timeout_reg;
        press_thr_next   = press_thr_reg;
        release_thr_next = release_thr_reg;
        installed_next   = installed_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SLEEP_TIMEOUT: begin
                    // timeout kept in ms
                    timeout_next = TO_W'(cfg_wdata[SLEEP_W-1:0] * TO_W'(TIMEOUT_UNIT_MS));
                end
                REG_PRESS_THRESHOLD: begin
                    press_thr_next = cfg_wdata[THR_W-1:0];
                end
                REG_RELEASE_THRESHOLD: begin
                    release_thr_next = cfg_wdata[THR_W-1:0];
                end
                REG_HANDLER_INSTALLED: begin
                    installed_next = cfg_wdata[INST_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= '0;
            press_thr_reg   <= THR_W'(4);
            release_thr_reg <= THR_W'(4);
            installed_reg   <= '0;
        end else begin
            timeout_reg     <= timeout_next;
            press_thr_reg   <= press_thr_next;
            release_thr_reg <= release_thr_next;
            installed_reg   <= installed_next;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic pressed_i;
        logic ok_i;
        logic inst_i;

        // buttons beyond the field width read as pressed, no handler
        if (i < FIELD_W) begin : g_bits
            assign pressed_i = !key_levels[i];
            assign ok_i      = handler_ok[i];
        end else begin : g_none
            assign pressed_i = 1'b1;
            assign ok_i      = 1'b0;
        end
        if (i < INST_W) begin : g_inst
            assign inst_i = installed_reg[i];
        end else begin : g_noinst
            assign inst_i = 1'b0;
        end

        mbda_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step_en     (step_en),
            .wake        (s_tuser),
            .pressed     (pressed_i),
            .ok          (ok_i),
            .installed   (inst_i),
            .press_thr   (press_thr_reg),
            .release_thr (release_thr_reg),
            .now_ms      (now_ms),
            .timeout     (timeout_reg),
            .res         (lane_res[i])
        );
    end

    mbda_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .lanes        (lane_res),
        .timeout_zero (timeout_reg == '0),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (out_data)
    );

    assign m_tdata = {(M_TDATA_W - $bits(result_t))'(0), out_data};

`ifndef NO_ASSERTIONS
    // input side only stalls when a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a handler can only fire on a button that is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[FIELD_W-1:0] & ~m_tdata[2*FIELD_W-1:FIELD_W]) == '0))
        else $error("fired without held");

    // every accepted item yields a pending result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");
`endif

endmodule
